>>> hw/rtl/assert_macros.svh
// Assertion helpers shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on the rising clock edge, held off while reset is low.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Concurrent assertion that a condition never holds outside of reset.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) else $error(msg);

`endif

>>> hw/rtl/deq_pkg.sv
// ----------------------------------------------------------------------------
// deq_pkg
// Shared types and constants of the double-ended queue.
// ----------------------------------------------------------------------------
package deq_pkg;

  localparam int DEPTH_DEFAULT     = 16;
  localparam int WORD_BITS_DEFAULT = 32;
  localparam int DATA_BITS         = 32;
  localparam int KIND_BITS         = 3;

  typedef enum logic [KIND_BITS-1:0] {
    KIND_PUSH_FRONT = 3'd0,
    KIND_PUSH_BACK  = 3'd1,
    KIND_POP_FRONT  = 3'd2,
    KIND_POP_BACK   = 3'd3,
    KIND_PEEK_FRONT = 3'd4,
    KIND_PEEK_BACK  = 3'd5,
    KIND_CLEAR      = 3'd6
  } kind_e;

  // Command broadcast to every cell of the chain at once.
  typedef struct packed {
    logic push_front;
    logic push_back;
    logic pop_front;
    logic pop_back;
    logic clear;
  } deq_cmd_t;

endpackage

>>> hw/rtl/deq_cell.sv
// ----------------------------------------------------------------------------
// deq_cell
// One storage cell of the queue chain: holds a word and its valid bit.
// ----------------------------------------------------------------------------
module deq_cell import deq_pkg::*; #(
  parameter int WORD_BITS = WORD_BITS_DEFAULT
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  deq_cmd_t             cmd_i,
  input  logic [WORD_BITS-1:0] push_word_i,
  input  logic                 left_valid_i,
  input  logic [WORD_BITS-1:0] left_word_i,
  input  logic                 right_valid_i,
  input  logic [WORD_BITS-1:0] right_word_i,
  output logic                 valid_o,
  output logic [WORD_BITS-1:0] word_o,
  output logic                 valid_next_o,
  output logic [WORD_BITS-1:0] back_word_o
);

  logic                 valid_q, valid_d;
  logic [WORD_BITS-1:0] word_q, word_d;
  logic                 is_back;
  logic                 is_hole;

  // The back element is the last valid cell; the first free cell takes a push at the back.
  assign is_back = valid_q & ~right_valid_i;
  assign is_hole = ~valid_q & left_valid_i;

  always_comb begin
    valid_d = valid_q;
    word_d  = word_q;
    if (cmd_i.push_front) begin
      valid_d = left_valid_i;
      word_d  = left_word_i;
    end else if (cmd_i.push_back) begin
      if (is_hole) begin
        valid_d = 1'b1;
        word_d  = push_word_i;
      end
    end else if (cmd_i.pop_front) begin
      valid_d = right_valid_i;
      word_d  = right_word_i;
    end else if (cmd_i.pop_back) begin
      if (is_back) begin
        valid_d = 1'b0;
      end
    end else if (cmd_i.clear) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign valid_o      = valid_q;
  assign word_o       = word_q;
  assign valid_next_o = valid_d;
  assign back_word_o  = is_back ? word_q : '0;

endmodule

>>> hw/rtl/double_ended_queue.sv
// ----------------------------------------------------------------------------
// double_ended_queue
// Bounded double-ended queue of words built as a shifting chain of cells.
// ----------------------------------------------------------------------------
// Each request (push front or back, pop front or back, peek front or back,
// clear) produces exactly one result carrying a success flag, the peeked word
// (zero unless a peek succeeded) and a flag telling whether the queue is empty
// after the request. Elements sit in a row of DEPTH cells with the front in
// cell 0: a push at the front shifts every cell one place toward the back, a
// pop at the front shifts every cell one place toward the front, and the back
// end is the last valid cell. A request is executed in the cycle it is
// accepted and its result appears in the output register in the next cycle, so
// a new request can be taken every cycle as long as the result side keeps up;
// the single output register is what sets that rate. Pushes on a full queue,
// and pops, peeks or clears on an empty queue, report failure and leave the
// queue unchanged, as does the unused kind code. Stored words are WORD_BITS
// wide; ports carry 32-bit words, truncated or zero-extended at the boundary.
// ----------------------------------------------------------------------------
module double_ended_queue import deq_pkg::*; #(
  parameter int DEPTH     = DEPTH_DEFAULT,
  parameter int WORD_BITS = WORD_BITS_DEFAULT
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [KIND_BITS-1:0] kind_i,
  input  logic [DATA_BITS-1:0] data_in_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic                 ok_o,
  output logic [DATA_BITS-1:0] data_out_o,
  output logic                 is_empty_o
);

  // Per-cell views of the chain.
  logic [DEPTH-1:0]                cell_valid;
  logic [DEPTH-1:0]                cell_valid_next;
  logic [DEPTH-1:0][WORD_BITS-1:0] cell_word;
  logic [DEPTH-1:0][WORD_BITS-1:0] cell_back;

  logic                 accept;
  logic                 is_empty;
  logic                 is_full;
  kind_e                kind;
  deq_cmd_t             cmd;
  logic [WORD_BITS-1:0] push_word;
  logic [WORD_BITS-1:0] back_word;
  logic [WORD_BITS-1:0] peek_word;
  logic                 ok;

  // Output register: one pending result at a time.
  logic                 out_valid_q, out_valid_d;
  logic                 ok_q;
  logic [DATA_BITS-1:0] data_q;
  logic                 empty_q;
  logic [DATA_BITS-1:0] peek_data;

  // A new request is taken when the output register is free or draining.
  assign in_ready_o = ~out_valid_q | out_ready_i;
  assign accept     = in_valid_i & in_ready_o;

  assign is_empty = ~cell_valid[0];
  assign is_full  = cell_valid[DEPTH-1];
  assign kind     = kind_e'(kind_i);

  // Bring the request word to storage width, and the stored word back to port width.
  if (WORD_BITS > DATA_BITS) begin : g_wide
    assign push_word = {{(WORD_BITS-DATA_BITS){1'b0}}, data_in_i};
    assign peek_data = peek_word[DATA_BITS-1:0];
  end else if (WORD_BITS < DATA_BITS) begin : g_narrow
    assign push_word = data_in_i[WORD_BITS-1:0];
    assign peek_data = {{(DATA_BITS-WORD_BITS){1'b0}}, peek_word};
  end else begin : g_same
    assign push_word = data_in_i;
    assign peek_data = peek_word;
  end

  // Decode the request into a chain command; failing requests become no-ops.
  always_comb begin
    cmd = '0;
    ok  = 1'b0;
    if (accept) begin
      case (kind)
        KIND_PUSH_FRONT: begin
          cmd.push_front = ~is_full;
          ok             = ~is_full;
        end
        KIND_PUSH_BACK: begin
          cmd.push_back = ~is_full;
          ok            = ~is_full;
        end
        KIND_POP_FRONT: begin
          cmd.pop_front = ~is_empty;
          ok            = ~is_empty;
        end
        KIND_POP_BACK: begin
          cmd.pop_back = ~is_empty;
          ok           = ~is_empty;
        end
        KIND_PEEK_FRONT: ok = ~is_empty;
        KIND_PEEK_BACK:  ok = ~is_empty;
        KIND_CLEAR: begin
          cmd.clear = ~is_empty;
          ok        = ~is_empty;
        end
        default: ok = 1'b0;
      endcase
    end
  end

  // The chain of cells. Cell 0 sees the pushed word as its front neighbor,
  // and the last cell sees an always-empty neighbor behind it.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                 left_valid;
    logic [WORD_BITS-1:0] left_word;
    logic                 right_valid;
    logic [WORD_BITS-1:0] right_word;

    if (i == 0) begin : g_first
      assign left_valid = 1'b1;
      assign left_word  = push_word;
    end else begin : g_inner_left
      assign left_valid = cell_valid[i-1];
      assign left_word  = cell_word[i-1];
    end

    if (i == DEPTH-1) begin : g_last
      assign right_valid = 1'b0;
      assign right_word  = '0;
    end else begin : g_inner_right
      assign right_valid = cell_valid[i+1];
      assign right_word  = cell_word[i+1];
    end

    deq_cell #(
      .WORD_BITS(WORD_BITS)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .cmd_i        (cmd),
      .push_word_i  (push_word),
      .left_valid_i (left_valid),
      .left_word_i  (left_word),
      .right_valid_i(right_valid),
      .right_word_i (right_word),
      .valid_o      (cell_valid[i]),
      .word_o       (cell_word[i]),
      .valid_next_o (cell_valid_next[i]),
      .back_word_o  (cell_back[i])
    );
  end

  // At most one cell flags itself as the back, so an OR over the gated words
  // selects the back element.
  always_comb begin
    back_word = '0;
    for (int i = 0; i < DEPTH; i++) begin
      back_word = back_word | cell_back[i];
    end
  end

  always_comb begin
    peek_word = '0;
    if (ok && kind == KIND_PEEK_FRONT) begin
      peek_word = cell_word[0];
    end else if (ok && kind == KIND_PEEK_BACK) begin
      peek_word = back_word;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (accept) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      ok_q    <= ok;
      data_q  <= peek_data;
      empty_q <= ~cell_valid_next[0];
    end
  end

  assign out_valid_o = out_valid_q;
  assign ok_o        = ok_q;
  assign data_out_o  = data_q;
  assign is_empty_o  = empty_q;

endmodule

>>> hw/rtl/deq_checker.sv
// ----------------------------------------------------------------------------
// deq_checker
// Port-level checks of the double-ended queue, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module deq_checker import deq_pkg::*; (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_ready_o,
  input logic [KIND_BITS-1:0] kind_i,
  input logic                 out_valid_o,
  input logic                 out_ready_i,
  input logic                 ok_o,
  input logic [DATA_BITS-1:0] data_out_o,
  input logic                 is_empty_o
);

  logic in_fire;
  logic out_stall;
  logic push_req;

  assign in_fire   = in_valid_i & in_ready_o;
  assign out_stall = out_valid_o & ~out_ready_i;
  assign push_req  = (kind_i == KIND_PUSH_FRONT) || (kind_i == KIND_PUSH_BACK);

  // A stalled result keeps its payload.
  `ASSERT_CLK(a_out_hold, clk_i, rst_ni, out_stall |=> out_valid_o && $stable(data_out_o) && $stable(ok_o), "result changed while stalled")

  // Every accepted request yields a result in the next cycle.
  `ASSERT_CLK(a_req_to_result, clk_i, rst_ni, in_fire |=> out_valid_o, "accepted request gave no result")

  // After a clear the queue is empty.
  `ASSERT_CLK(a_clear_empties, clk_i, rst_ni, in_fire && (kind_i == KIND_CLEAR) |=> is_empty_o, "queue not empty after clear")

  // A successful push leaves the queue non-empty.
  `ASSERT_CLK(a_push_fills, clk_i, rst_ni, in_fire && push_req |=> !ok_o || !is_empty_o, "queue empty after successful push")

  // A free output register never refuses a request.
  `ASSERT_NEVER(a_ready_when_idle, clk_i, rst_ni, !out_valid_o && !in_ready_o, "request refused with no pending result")

endmodule

bind double_ended_queue deq_checker u_deq_checker (.*);

>>> tb/tb_double_ended_queue.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_double_ended_queue
// Self-checking testbench for the bounded double-ended queue.
// ----------------------------------------------------------------------------
// The testbench keeps its own ring-buffer model of the queue. It predicts the
// result of every request at the moment the request is accepted, and a
// checker compares each result leaving the block with the oldest prediction.
// Directed tests cover the empty queue, a single element and the full queue.
// A long output stall fills the block and stalls its input. A pause lets
// every result drain. Random bursts then swing the fill level between empty
// and full. Both sides insert random idle gaps.
// ----------------------------------------------------------------------------
module tb_double_ended_queue import deq_pkg::*;;

  localparam int DEPTH      = DEPTH_DEFAULT;
  localparam int IDX_BITS   = $clog2(DEPTH);
  localparam int FILL_BITS  = $clog2(DEPTH + 1);
  localparam int MAX_SHOWN  = 10;
  localparam int BURSTS     = 14;
  localparam int BURST_LEN  = 50;
  // The package leaves code 7 unnamed; the block must ignore it.
  localparam logic [KIND_BITS-1:0] KIND_UNUSED = 3'd7;

  // One result as the block reports it.
  typedef struct packed {
    logic                 ok;
    logic [DATA_BITS-1:0] data;
    logic                 empty;
  } deq_result_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_ready_o;
  logic [KIND_BITS-1:0] kind_i;
  logic [DATA_BITS-1:0] data_in_i;
  logic                 out_valid_o;
  logic                 out_ready_i;
  logic                 ok_o;
  logic [DATA_BITS-1:0] data_out_o;
  logic                 is_empty_o;

  // Shadow copy of the queue contents used for prediction.
  logic [DATA_BITS-1:0] ring_words [DEPTH];
  logic [IDX_BITS-1:0]  ring_front;
  logic [FILL_BITS-1:0] ring_fill;

  deq_result_t expected_results [$];
  int          mismatch_count = 0;

  // When set, both sides stop idling for a stretch.
  bit no_idle = 1'b0;
  // Length of a requested receiver hold-off, in cycles; zero when none.
  int stall_cycles = 0;

  double_ended_queue dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .kind_i      (kind_i),
    .data_in_i   (data_in_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .ok_o        (ok_o),
    .data_out_o  (data_out_o),
    .is_empty_o  (is_empty_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // Slot holding the element pos places behind the front, wrapping around.
  function automatic logic [IDX_BITS-1:0] ring_slot(input logic [FILL_BITS-1:0] pos);
    logic [FILL_BITS-1:0] sum;
    sum = ring_front + pos;
    return sum[IDX_BITS-1:0];
  endfunction

  // Applies one request to the shadow queue and returns the result it causes.
  task automatic apply_request(input logic [KIND_BITS-1:0] kind,
                               input logic [DATA_BITS-1:0] word,
                               output deq_result_t res);
    res = '0;
    case (kind)
      KIND_PUSH_FRONT: begin
        if (ring_fill < DEPTH) begin
          // The ring depth is a power of two, so the decrement wraps.
          ring_front = ring_front - 1'b1;
          ring_words[ring_front] = word;
          ring_fill = ring_fill + 1'b1;
          res.ok = 1'b1;
        end
      end
      KIND_PUSH_BACK: begin
        if (ring_fill < DEPTH) begin
          ring_words[ring_slot(ring_fill)] = word;
          ring_fill = ring_fill + 1'b1;
          res.ok = 1'b1;
        end
      end
      KIND_POP_FRONT: begin
        if (ring_fill != 0) begin
          ring_front = ring_front + 1'b1;
          ring_fill = ring_fill - 1'b1;
          res.ok = 1'b1;
        end
      end
      KIND_POP_BACK: begin
        if (ring_fill != 0) begin
          ring_fill = ring_fill - 1'b1;
          res.ok = 1'b1;
        end
      end
      KIND_PEEK_FRONT: begin
        if (ring_fill != 0) begin
          res.data = ring_words[ring_slot('0)];
          res.ok = 1'b1;
        end
      end
      KIND_PEEK_BACK: begin
        if (ring_fill != 0) begin
          res.data = ring_words[ring_slot(ring_fill - 1'b1)];
          res.ok = 1'b1;
        end
      end
      KIND_CLEAR: begin
        // Clearing an empty queue reports failure.
        if (ring_fill != 0) begin
          ring_fill = '0;
          res.ok = 1'b1;
        end
      end
      default: begin
        // The unused code leaves everything as it is.
      end
    endcase
    res.empty = (ring_fill == 0);
  endtask

  // ---------------------------------------------------------------------------
  // Checker: one process records accepted requests and checks results.
  // Requests are recorded first so that a result leaving in the same cycle
  // would still find its prediction.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    deq_result_t predicted;
    deq_result_t actual;
    deq_result_t wanted;
    if (!rst_ni) begin
      ring_front = '0;
      ring_fill  = '0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        apply_request(kind_i, data_in_i, predicted);
        expected_results.push_back(predicted);
      end
      if (out_valid_o && out_ready_i) begin
        actual = '{ok: ok_o, data: data_out_o, empty: is_empty_o};
        if (expected_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= MAX_SHOWN)
            $display("%0t: result with no request pending: ok=%0b data=%08h empty=%0b",
                     $realtime, actual.ok, actual.data, actual.empty);
        end else begin
          wanted = expected_results.pop_front();
          if (actual.ok !== wanted.ok || actual.data !== wanted.data ||
              actual.empty !== wanted.empty) begin
            mismatch_count++;
            if (mismatch_count <= MAX_SHOWN)
              $display("%0t: mismatch: expected ok=%0b data=%08h empty=%0b, got ok=%0b data=%08h empty=%0b",
                       $realtime, wanted.ok, wanted.data, wanted.empty,
                       actual.ok, actual.data, actual.empty);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Idle gaps: mostly none or short, now and then long.
  // ---------------------------------------------------------------------------
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle)  return 0;
    if (r < 65)   return 0;
    if (r < 94)   return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Data words lean toward the extremes now and then.
  function automatic logic [DATA_BITS-1:0] pick_word();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return $urandom();
  endfunction

  // Receiver: random ready gaps, plus a long hold-off when a test asks for it.
  initial begin
    int gap;
    out_ready_i <= 1'b0;
    @(posedge rst_ni);
    forever begin
      if (stall_cycles > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall_cycles) @(posedge clk_i);
        stall_cycles = 0;
      end else begin
        gap = pick_gap();
        if (gap == 0) begin
          out_ready_i <= 1'b1;
          @(posedge clk_i);
        end else begin
          out_ready_i <= 1'b0;
          repeat (gap) @(posedge clk_i);
          out_ready_i <= 1'b1;
          @(posedge clk_i);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sender
  // ---------------------------------------------------------------------------

  // Offers one request, holds it until accepted, then idles at random.
  // Called and returns just after a rising edge.
  task automatic send_request(input logic [KIND_BITS-1:0] kind,
                              input logic [DATA_BITS-1:0] word);
    int gap;
    in_valid_i <= 1'b1;
    kind_i     <= kind;
    data_in_i  <= word;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Stops offering requests until every predicted result has come back.
  // The first edge lets the checker record the last accepted request.
  task automatic wait_all_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_results.size() != 0) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Every removing, reading and clearing request, and the unused code, fails on an empty queue.
  task automatic test_empty_requests();
    send_request(KIND_POP_FRONT, '1);
    send_request(KIND_POP_BACK, '0);
    send_request(KIND_PEEK_FRONT, '1);
    send_request(KIND_PEEK_BACK, '0);
    send_request(KIND_CLEAR, '1);
    send_request(KIND_UNUSED, '1);
  endtask

  // A single element is reachable from both ends, and removing it empties
  // the queue from either end.
  task automatic test_single_element();
    send_request(KIND_PUSH_BACK, '0);
    send_request(KIND_PEEK_FRONT, '1);
    send_request(KIND_PEEK_BACK, '1);
    send_request(KIND_POP_FRONT, '1);
    send_request(KIND_PUSH_FRONT, '1);
    send_request(KIND_PEEK_BACK, '0);
    send_request(KIND_POP_BACK, '0);
    send_request(KIND_PUSH_FRONT, 32'hA5A5_5A5A);
    send_request(KIND_PUSH_BACK, 32'h5A5A_A5A5);
    send_request(KIND_PEEK_FRONT, '0);
    send_request(KIND_PEEK_BACK, '0);
    send_request(KIND_UNUSED, '0);
    // Clear on a non-empty queue succeeds, and a second clear fails.
    send_request(KIND_CLEAR, '0);
    send_request(KIND_CLEAR, '0);
  endtask

  // Fill the queue from both ends; pushes on a full queue fail at either end.
  task automatic test_full_queue();
    for (int i = 0; i < DEPTH; i++)
      send_request((i % 2 == 0) ? KIND_PUSH_FRONT : KIND_PUSH_BACK, pick_word());
    send_request(KIND_PUSH_FRONT, '1);
    send_request(KIND_PUSH_BACK, '1);
    send_request(KIND_PEEK_FRONT, '0);
    send_request(KIND_PEEK_BACK, '0);
    send_request(KIND_POP_BACK, '0);
    send_request(KIND_PUSH_BACK, '1);
    send_request(KIND_PEEK_BACK, '0);
    send_request(KIND_CLEAR, '0);
  endtask

  // The receiver holds off for a long stretch while requests keep coming,
  // so the output register fills and the block stalls its input.
  task automatic test_output_stall();
    wait_all_results();
    stall_cycles = 200;
    for (int i = 0; i < 30; i++)
      send_request((i < 20) ? KIND_PUSH_BACK : KIND_PEEK_FRONT, pick_word());
  endtask

  // The sender pauses mid-sequence until every result is back.
  task automatic test_drain_pause();
    for (int i = 0; i < 10; i++)
      send_request(KIND_BITS'(KIND_POP_FRONT + ($urandom_range(0, 3) == 0)), pick_word());
    wait_all_results();
    for (int i = 0; i < 10; i++)
      send_request(KIND_BITS'($urandom_range(0, 5)), pick_word());
  endtask

  // Bursts alternate between push-heavy and pop-heavy mixes so the fill
  // level keeps swinging between empty and full, with peeks, clears and
  // the unused code sprinkled in.
  task automatic test_random_bursts();
    int r;
    int push_pct;
    logic [KIND_BITS-1:0] kind;
    for (int b = 0; b < BURSTS; b++) begin
      push_pct = (b % 2 == 0) ? $urandom_range(70, 90) : $urandom_range(15, 35);
      no_idle  = (b % 5 == 3);
      for (int i = 0; i < BURST_LEN; i++) begin
        r = $urandom_range(0, 99);
        if (r < 3)
          kind = KIND_CLEAR;
        else if (r < 5)
          kind = KIND_UNUSED;
        else if (r < 25)
          kind = $urandom_range(0, 1) ? KIND_PEEK_FRONT : KIND_PEEK_BACK;
        else if ($urandom_range(0, 99) < push_pct)
          kind = $urandom_range(0, 1) ? KIND_PUSH_FRONT : KIND_PUSH_BACK;
        else
          kind = $urandom_range(0, 1) ? KIND_POP_FRONT : KIND_POP_BACK;
        send_request(kind, pick_word());
      end
      if (b % 4 == 2) wait_all_results();
    end
    no_idle = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_ni     <= 1'b0;
    in_valid_i <= 1'b0;
    kind_i     <= '0;
    data_in_i  <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_requests();
    test_single_element();
    test_full_queue();
    test_output_stall();
    test_drain_pause();
    test_random_bursts();

    wait_all_results();
    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0 && expected_results.size() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

  // Watchdog, far beyond the slowest correct run.
  initial begin
    #5000000;
    $display("tb: failure");
    $finish;
  end

endmodule
